// File: sv/dll_pkg.sv
// package for the linked list block: widths, op codes, controller states
`default_nettype none
package dll_pkg;
   localparam int CAPACITY_DEF   = 256;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int KIND_W         = 4;

   typedef enum logic [3:0] {
      OP_INS_HEAD   = 4'd0,
      OP_INS_TAIL   = 4'd1,
      OP_POP_HEAD   = 4'd2,
      OP_POP_TAIL   = 4'd3,
      OP_CUR_HEAD   = 4'd4,
      OP_CUR_TAIL   = 4'd5,
      OP_FWD        = 4'd6,
      OP_BACK       = 4'd7,
      OP_INS_AFTER  = 4'd8,
      OP_INS_BEFORE = 4'd9,
      OP_DELETE     = 4'd10,
      OP_CLEAR      = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_LOOK,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture word, issue link reads around the cursor, head and tail
      logic fetch;   // read the free list link and the cursor value
      logic exec;    // perform the operation using read data
      logic look;    // read values of head and tail
      logic finish;  // register the response word
   } cmd_type;
endpackage
`default_nettype wire

// File: sv/dll_if.sv
// valid/ready channel interface
`default_nettype none
interface dll_if #(parameter int W = 8) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/dll_ctrl.sv
// controller state machine sequencing each list operation
`default_nettype none
module dll_ctrl import dll_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire logic out_busy,
   output cmd_type   cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (in_valid) state_in = ST_READ;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: state_in = ST_LOOK;
         ST_LOOK: state_in = ST_DONE;
         ST_DONE: if (!out_busy) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         ST_READ: cmd.fetch = 1'b1;
         ST_EXEC: cmd.exec = 1'b1;
         ST_LOOK: cmd.look = 1'b1;
         ST_DONE: cmd.finish = !out_busy;
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) cmd.load |=> !in_ready);
   assert property (@(posedge clock) disable iff (reset) cmd.exec |=> cmd.look);
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.fetch, cmd.exec, cmd.look, cmd.finish}));
endmodule
`default_nettype wire

// File: sv/dll_dp.sv
// datapath: node memories, list pointers, allocator and response register
`default_nettype none
module dll_dp import dll_pkg::*; #(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire logic [KIND_W-1:0]     kind,
   input  wire logic [DATA_WIDTH-1:0] item_value,
   output logic                       ok,
   output logic [DATA_WIDTH-1:0]      removed_value,
   output logic [$clog2(CAPACITY+1)-1:0] length,
   output logic                       is_empty,
   output logic                       at_first,
   output logic                       at_last,
   output logic                       cursor_valid,
   output logic [DATA_WIDTH-1:0]      first_value,
   output logic [DATA_WIDTH-1:0]      last_value,
   output logic [DATA_WIDTH-1:0]      cursor_value
);
   localparam int PW = $clog2(CAPACITY+1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [PW-1:0] NIL = PW'(CAPACITY);

   logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
   logic [PW-1:0]         next_mem [CAPACITY];
   logic [PW-1:0]         prev_mem [CAPACITY];

   logic [PW-1:0] head_ff, tail_ff, cur_ff, count_ff, free_ff, fresh_ff;
   logic [KIND_W-1:0]     kind_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   // reads of the cursor node (next, prev), the head/tail nodes and the free list head
   logic [PW-1:0] cnext_ff, cprev_ff, hnext_ff, tprev_ff, fnext_ff;
   logic [DATA_WIDTH-1:0] hv_ff, tv_ff, cval_ff, rm_ff;
   logic ok_ff;

   function automatic logic [AW-1:0] ix(input logic [PW-1:0] p);
      return p[AW-1:0];
   endfunction

   // stage one: links around the cursor, head and tail; stage two: free list and cursor value
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= kind;
         val_ff   <= item_value;
         cnext_ff <= next_mem[ix(cur_ff)];
         hnext_ff <= next_mem[ix(head_ff)];
         cprev_ff <= prev_mem[ix(cur_ff)];
         tprev_ff <= prev_mem[ix(tail_ff)];
         hv_ff    <= val_mem[ix(head_ff)];
         tv_ff    <= val_mem[ix(tail_ff)];
      end
      if (cmd.fetch) begin
         fnext_ff <= next_mem[ix(free_ff)];
         cval_ff  <= val_mem[ix(cur_ff)];
      end
   end

   // execute decisions
   logic cvalid;
   logic do_ins, do_rm;
   logic [PW-1:0] ip, inn, rk, rp, rn, newk, cur_n;
   logic [DATA_WIDTH-1:0] rv;
   logic from_free, can_alloc;
   always_comb begin
      cvalid = cur_ff != NIL;
      do_ins = 1'b0; do_rm = 1'b0;
      ip = NIL; inn = NIL; rk = NIL; rp = NIL; rn = NIL; rv = '0;
      cur_n = cur_ff;
      from_free = free_ff != NIL;
      can_alloc = from_free || (fresh_ff != NIL);
      newk = from_free ? free_ff : fresh_ff;
      case (kind_ff)
         OP_INS_HEAD: begin do_ins = can_alloc; ip = NIL; inn = head_ff; end
         OP_INS_TAIL: begin do_ins = can_alloc; ip = tail_ff; inn = NIL; end
         OP_INS_AFTER: begin
            do_ins = can_alloc;
            if (cvalid) begin ip = cur_ff; inn = cnext_ff; end
            else begin ip = tail_ff; inn = NIL; end
         end
         OP_INS_BEFORE: begin
            do_ins = can_alloc;
            if (cvalid) begin ip = cprev_ff; inn = cur_ff; end
            else begin ip = NIL; inn = head_ff; end
         end
         OP_POP_HEAD: if (head_ff != NIL) begin
            do_rm = 1'b1; rk = head_ff; rp = NIL; rn = hnext_ff; rv = hv_ff;
            if (cur_ff == head_ff) cur_n = hnext_ff;
         end
         OP_POP_TAIL: if (tail_ff != NIL) begin
            do_rm = 1'b1; rk = tail_ff; rp = tprev_ff; rn = NIL; rv = tv_ff;
            if (cur_ff == tail_ff) cur_n = tprev_ff;
         end
         OP_DELETE: if (cvalid) begin
            do_rm = 1'b1; rk = cur_ff; rp = cprev_ff; rn = cnext_ff; rv = cval_ff;
            cur_n = (cur_ff == tail_ff) ? cprev_ff : cnext_ff;
         end
         default: ;
      endcase
   end

   logic ok_c;
   always_comb begin
      case (kind_ff)
         OP_INS_HEAD, OP_INS_TAIL, OP_INS_AFTER, OP_INS_BEFORE: ok_c = do_ins;
         OP_POP_HEAD, OP_POP_TAIL, OP_DELETE: ok_c = do_rm;
         OP_CUR_HEAD: ok_c = head_ff != NIL;
         OP_CUR_TAIL: ok_c = tail_ff != NIL;
         OP_FWD:  ok_c = cvalid && cur_ff != tail_ff;
         OP_BACK: ok_c = cvalid && cur_ff != head_ff;
         OP_CLEAR: ok_c = 1'b1;
         default: ok_c = 1'b0;
      endcase
   end

   // memory writes: up to two link updates plus node fields
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (do_ins) begin
            val_mem[ix(newk)]  <= val_ff;
            prev_mem[ix(newk)] <= ip;
            next_mem[ix(newk)] <= inn;
            if (ip != NIL) next_mem[ix(ip)] <= newk;
            if (inn != NIL) prev_mem[ix(inn)] <= newk;
         end
         if (do_rm) begin
            if (rp != NIL) next_mem[ix(rp)] <= rn;
            if (rn != NIL) prev_mem[ix(rn)] <= rp;
            next_mem[ix(rk)] <= free_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= NIL; tail_ff <= NIL; cur_ff <= NIL;
         count_ff <= '0; free_ff <= NIL; fresh_ff <= '0;
         ok <= 1'b0;
      end else if (cmd.exec) begin
         ok_ff <= ok_c;
         rm_ff <= rv;
         case (kind_ff)
            OP_CUR_HEAD: cur_ff <= head_ff;
            OP_CUR_TAIL: cur_ff <= tail_ff;
            OP_FWD:  if (ok_c) cur_ff <= cnext_ff;
            OP_BACK: if (ok_c) cur_ff <= cprev_ff;
            OP_CLEAR: begin
               head_ff <= NIL; tail_ff <= NIL; cur_ff <= NIL;
               count_ff <= '0; free_ff <= NIL; fresh_ff <= '0;
            end
            default: ;
         endcase
         if (do_ins) begin
            if (from_free) free_ff <= fnext_ff;
            else fresh_ff <= fresh_ff + 1'b1;
            if (ip == NIL) head_ff <= newk;
            if (inn == NIL) tail_ff <= newk;
            count_ff <= count_ff + 1'b1;
         end
         if (do_rm) begin
            cur_ff <= cur_n;
            if (rp == NIL) head_ff <= rn;
            if (rn == NIL) tail_ff <= rp;
            count_ff <= count_ff - 1'b1;
            free_ff <= rk;
         end
      end else if (cmd.finish) begin
         ok <= ok_ff;
      end
   end

   // look stage: read values at the new head and tail
   logic [DATA_WIDTH-1:0] lh_ff, lt_ff;
   always_ff @(posedge clock) begin
      if (cmd.look) begin
         lh_ff <= val_mem[ix(head_ff)];
         lt_ff <= val_mem[ix(tail_ff)];
      end
   end

   // cursor value is read straight into the response register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         removed_value <= rm_ff;
         length        <= count_ff;
         is_empty      <= count_ff == '0;
         cursor_valid  <= cur_ff != NIL;
         at_first      <= cur_ff != NIL && cur_ff == head_ff;
         at_last       <= cur_ff != NIL && cur_ff == tail_ff;
         first_value   <= (head_ff != NIL) ? lh_ff : '0;
         last_value    <= (tail_ff != NIL) ? lt_ff : '0;
         cursor_value  <= (cur_ff != NIL) ? val_mem[ix(cur_ff)] : '0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (head_ff == NIL) == (count_ff == '0));
   assert property (@(posedge clock) disable iff (reset)
      (head_ff == NIL) == (tail_ff == NIL));
   assert property (@(posedge clock) disable iff (reset) count_ff <= NIL);
endmodule
`default_nettype wire

// File: sv/doubly_linked_list_with_cursor.sv
// top level: linked list with one cursor over a fixed node pool
// an accepted request word steps through the read, execute, value look and respond states
// a new request word is taken only in idle, after the previous response word is registered
// two-port node memories set the read, write, read sequence; respond waits on an unread word
// reset (synchronous, active high) empties the list, invalidates the cursor
// and resets the allocator; node memories are not cleared
`default_nettype none
module doubly_linked_list_with_cursor import dll_pkg::*; #(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   dll_if.sink   req,
   dll_if.source rsp
);
   localparam int PW = $clog2(CAPACITY+1);

   // request word: {kind, item_value}
   logic [KIND_W-1:0]     req_kind;
   logic [DATA_WIDTH-1:0] req_item_value;
   assign req_kind       = req.data[KIND_W+DATA_WIDTH-1:DATA_WIDTH];
   assign req_item_value = req.data[DATA_WIDTH-1:0];

   cmd_type cmd;
   logic    rsp_valid_ff;

   // controller waits in respond state while the previous word is unread
   dll_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid),
      .in_ready(req.ready),
      .out_busy(rsp_valid_ff && !rsp.ready),
      .cmd
   );

   logic                  ok, is_empty, at_first, at_last, cursor_valid;
   logic [DATA_WIDTH-1:0] removed_value, first_value, last_value, cursor_value;
   logic [PW-1:0]         length;

   dll_dp #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock, .reset, .cmd,
      .kind(req_kind), .item_value(req_item_value),
      .ok, .removed_value, .length, .is_empty, .at_first, .at_last,
      .cursor_valid, .first_value, .last_value, .cursor_value
   );

   // response valid flag; the payload register lives in the datapath
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp.valid = rsp_valid_ff;
   // response word packed msb first in field order
   assign rsp.data = {ok, removed_value, length, is_empty, at_first, at_last,
                      cursor_valid, first_value, last_value, cursor_value};

   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff);
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff);
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> !cmd.finish);
endmodule
`default_nettype wire
